// File: hw/rtl/socd_last_input_key_cleaner_core_defines.svh
// Assertion macros shared by the key cleaner RTL files.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef SOCD_LAST_INPUT_KEY_CLEANER_CORE_DEFINES_SVH
`define SOCD_LAST_INPUT_KEY_CLEANER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SOCD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SOCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/socd_pkg.sv
// Shared types, codes and helper functions for the last-input key cleaner.
// Used by socd_front, socd_queue, socd_back and the top level.
package socd_pkg;

	localparam int TIMER_BITS = 16;
	localparam int DELAY_W    = 16;
	localparam int NUM_KEYS   = 4;
	localparam int RES_MAX    = 4;
	localparam int RES_CNT_W  = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int Q_DEPTH    = 2;

	// Input kinds.
	localparam logic MODE_EVENT = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	// Physical key codes.
	localparam logic [2:0] KEY_UP      = 3'd0;
	localparam logic [2:0] KEY_DOWN    = 3'd1;
	localparam logic [2:0] KEY_RIGHT   = 3'd2;
	localparam logic [2:0] KEY_LEFT    = 3'd3;
	localparam logic [2:0] KEY_JUMP    = 3'd4;
	localparam logic [2:0] KEY_REL_TGL = 3'd5;
	localparam logic [2:0] KEY_BRG_TGL = 3'd6;
	localparam logic [2:0] KEY_OTHER   = 3'd7;

	// Virtual key codes.
	localparam logic [1:0] VK_UP    = 2'd0;
	localparam logic [1:0] VK_DOWN  = 2'd1;
	localparam logic [1:0] VK_RIGHT = 2'd2;
	localparam logic [1:0] VK_LEFT  = 2'd3;

	// Key actions.
	localparam logic [1:0] ACT_RELEASE = 2'd0;
	localparam logic [1:0] ACT_PRESS   = 2'd1;

	// Last-side codes; the bridge side uses the same encoding (right = positive).
	localparam logic [1:0] SIDE_NONE = 2'd0;
	localparam logic [1:0] SIDE_POS  = 2'd1;
	localparam logic [1:0] SIDE_NEG  = 2'd2;

	localparam logic AXIS_VERT  = 1'b0;
	localparam logic AXIS_HORIZ = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_UP        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LEFT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BRIDGE_AT_START = 3'd4;

	typedef struct packed {
		logic                  active;
		logic                  pending;
		logic                  pval;
		logic [TIMER_BITS-1:0] cnt;
	} key_st_t;

	typedef struct packed {
		key_st_t ks;
		logic    emit;
	} key_upd_t;

	// All results caused by one input item, in emission order.
	typedef struct packed {
		logic [RES_CNT_W-1:0]      cnt;
		logic [RES_MAX-1:0][1:0]   vk;
		logic [RES_MAX-1:0]        pr;
	} bundle_t;

	function automatic logic [TIMER_BITS-1:0] timer_load(input logic [DELAY_W-1:0] dly);
		logic [31:0] d;
		logic [31:0] m;
		d = 32'(dly);
		m = 32'((64'd1 << TIMER_BITS) - 64'd1);
		return (d > m) ? TIMER_BITS'(m) : TIMER_BITS'(d);
	endfunction

	function automatic key_upd_t set_key(input key_st_t ks, input logic [DELAY_W-1:0] dly,
			input logic target, input logic instant);
		key_upd_t r;
		r.ks   = ks;
		r.emit = 1'b0;
		if (dly == '0 || (instant && target)) begin
			r.emit       = (target != ks.active);
			r.ks.active  = target;
			r.ks.pending = 1'b0;
		end else if (target == ks.active) begin
			r.ks.pending = 1'b0;
		end else begin
			r.ks.pending = 1'b1;
			r.ks.cnt     = timer_load(dly);
			r.ks.pval    = target;
		end
		return r;
	endfunction

	function automatic bundle_t add_res(input bundle_t b, input logic [1:0] vk,
			input logic pr);
		bundle_t r;
		r = b;
		if (b.cnt < RES_CNT_W'(RES_MAX)) begin
			r.vk[b.cnt[1:0]] = vk;
			r.pr[b.cnt[1:0]] = pr;
			r.cnt            = b.cnt + RES_CNT_W'(1);
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/socd_front.sv
// Front part of the key cleaner: configuration registers, key state, and the
// classification of each input beat into a bundle of results. Uses socd_pkg.
`include "socd_last_input_key_cleaner_core_defines.svh"

module socd_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [socd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [socd_pkg::DELAY_W-1:0]      cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,
	input  logic                              s_tuser,
	output logic                              push,
	output socd_pkg::bundle_t                 push_data,
	input  logic                              q_ready
);

	logic [socd_pkg::DELAY_W-1:0] delay_q [socd_pkg::NUM_KEYS];
	socd_pkg::key_st_t            keys_q  [socd_pkg::NUM_KEYS];
	logic [3:0]                   held_q;
	logic [1:0]                   last_side_q [2];
	logic [1:0]                   bside_q;
	logic                         roj_q;
	logic                         bmode_q;
	logic                         jump_q;

	socd_pkg::key_st_t n_keys [socd_pkg::NUM_KEYS];
	logic [3:0]        n_held;
	logic [1:0]        n_last_side [2];
	logic [1:0]        n_bside;
	logic              n_roj;
	logic              n_bmode;
	logic              n_jump;
	socd_pkg::bundle_t bun;
	logic              accept;
	logic [3:0]        pend_zero_w;

	logic [2:0] key_id;
	logic [1:0] key_act;

	assign key_id   = s_tdata[2:0];
	assign key_act  = s_tdata[4:3];
	assign s_tready = q_ready;
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && (bun.cnt != '0);
	assign push_data = bun;

	always_comb begin
		logic                  do_upd;
		logic                  ax;
		logic                  is_pos;
		logic                  press;
		logic                  rel;
		logic [1:0]            pk;
		logic [1:0]            nk;
		logic                  p;
		logic                  n;
		logic                  pt;
		logic                  nt;
		logic                  idle;
		socd_pkg::key_upd_t    up_p;
		socd_pkg::key_upd_t    up_n;
		logic [socd_pkg::TIMER_BITS-1:0] dec;

		for (int i = 0; i < socd_pkg::NUM_KEYS; i++) n_keys[i] = keys_q[i];
		n_held         = held_q;
		n_last_side[0] = last_side_q[0];
		n_last_side[1] = last_side_q[1];
		n_bside        = bside_q;
		n_roj          = roj_q;
		n_bmode        = bmode_q;
		n_jump         = jump_q;
		bun            = '0;
		dec            = '0;
		do_upd         = 1'b0;
		ax             = key_id[1];
		is_pos         = !key_id[0];
		press          = (key_act == socd_pkg::ACT_PRESS);
		rel            = (key_act == socd_pkg::ACT_RELEASE);

		if (s_tuser == socd_pkg::MODE_TICK) begin
			// Countdowns run in parallel; keys finish in order up, down, right, left.
			for (int i = 0; i < socd_pkg::NUM_KEYS; i++) begin
				if (keys_q[i].pending) begin
					dec = (keys_q[i].cnt != '0) ? keys_q[i].cnt - 1'b1 : keys_q[i].cnt;
					n_keys[i].cnt = dec;
					if (dec == '0) begin
						if (keys_q[i].pval != keys_q[i].active)
							bun = socd_pkg::add_res(bun, 2'(i), keys_q[i].pval);
						n_keys[i].active  = keys_q[i].pval;
						n_keys[i].pending = 1'b0;
					end
				end
			end
		end else if (press || rel) begin
			unique case (key_id) inside
				socd_pkg::KEY_UP, socd_pkg::KEY_DOWN,
				socd_pkg::KEY_RIGHT, socd_pkg::KEY_LEFT: begin
					if (press && !held_q[key_id[1:0]]) begin
						n_held[key_id[1:0]] = 1'b1;
						n_last_side[ax] = is_pos ? socd_pkg::SIDE_POS : socd_pkg::SIDE_NEG;
						if (ax == socd_pkg::AXIS_HORIZ) n_bside = socd_pkg::SIDE_NONE;
						do_upd = 1'b1;
					end else if (rel) begin
						n_held[key_id[1:0]] = 1'b0;
						// Both horizontal keys let go under jump in bridge mode: hold the opposite side.
						if (ax == socd_pkg::AXIS_HORIZ && bmode_q && jump_q &&
								!n_held[2] && !n_held[3])
							n_bside = is_pos ? socd_pkg::SIDE_NEG : socd_pkg::SIDE_POS;
						do_upd = 1'b1;
					end
				end
				socd_pkg::KEY_JUMP: begin
					if (press && !jump_q) begin
						n_jump = 1'b1;
						if (roj_q) begin
							if (keys_q[socd_pkg::VK_UP].active)
								bun = socd_pkg::add_res(bun, socd_pkg::VK_UP, 1'b0);
							n_keys[socd_pkg::VK_UP].active  = 1'b0;
							n_keys[socd_pkg::VK_UP].pending = 1'b0;
						end
					end else if (rel) begin
						n_jump  = 1'b0;
						n_bside = socd_pkg::SIDE_NONE;
						ax      = socd_pkg::AXIS_HORIZ;
						do_upd  = 1'b1;
					end
				end
				socd_pkg::KEY_REL_TGL: begin
					if (press) n_roj = !roj_q;
				end
				socd_pkg::KEY_BRG_TGL: begin
					if (press) begin
						n_bmode = !bmode_q;
						if (bmode_q) begin
							n_bside = socd_pkg::SIDE_NONE;
							ax      = socd_pkg::AXIS_HORIZ;
							do_upd  = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end

		pk = {ax, 1'b0};
		nk = {ax, 1'b1};
		p  = n_held[pk];
		n  = n_held[nk];
		pt = p && (!n || n_last_side[ax] == socd_pkg::SIDE_POS);
		nt = n && (!p || n_last_side[ax] == socd_pkg::SIDE_NEG);
		if (ax == socd_pkg::AXIS_HORIZ && n_bmode && n_jump && !p && !n) begin
			if (n_bside == socd_pkg::SIDE_POS) pt = 1'b1;
			else if (n_bside == socd_pkg::SIDE_NEG) nt = 1'b1;
		end
		idle = !n_keys[pk].active && !n_keys[nk].active &&
			!n_keys[pk].pending && !n_keys[nk].pending;
		up_p = socd_pkg::set_key(n_keys[pk], delay_q[pk], pt, idle);
		up_n = socd_pkg::set_key(n_keys[nk], delay_q[nk], nt, idle);
		if (do_upd) begin
			n_keys[pk] = up_p.ks;
			n_keys[nk] = up_n.ks;
			if (up_p.emit) bun = socd_pkg::add_res(bun, pk, pt);
			if (up_n.emit) bun = socd_pkg::add_res(bun, nk, nt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < socd_pkg::NUM_KEYS; i++) begin
				delay_q[i] <= '0;
				keys_q[i]  <= '0;
			end
			held_q         <= '0;
			last_side_q[0] <= socd_pkg::SIDE_NONE;
			last_side_q[1] <= socd_pkg::SIDE_NONE;
			bside_q        <= socd_pkg::SIDE_NONE;
			roj_q          <= 1'b1;
			bmode_q        <= 1'b0;
			jump_q         <= 1'b0;
		end else begin
			if (accept) begin
				for (int i = 0; i < socd_pkg::NUM_KEYS; i++) keys_q[i] <= n_keys[i];
				held_q         <= n_held;
				last_side_q[0] <= n_last_side[0];
				last_side_q[1] <= n_last_side[1];
				bside_q        <= n_bside;
				roj_q          <= n_roj;
				jump_q         <= n_jump;
			end
			if (cfg_we && cfg_index == socd_pkg::CFG_BRIDGE_AT_START)
				bmode_q <= cfg_wdata[0];
			else if (accept)
				bmode_q <= n_bmode;
			if (cfg_we && cfg_index <= socd_pkg::CFG_DELAY_LEFT)
				delay_q[cfg_index[1:0]] <= cfg_wdata;
		end
	end

	always_comb begin
		for (int i = 0; i < socd_pkg::NUM_KEYS; i++)
			pend_zero_w[i] = keys_q[i].pending && (keys_q[i].cnt == '0);
	end

	// A pending change always has time left to run.
	`SOCD_ASSERT_SAME(a_pend_has_time, 1'b1, pend_zero_w == '0, "pending key with zero countdown")
	// A bundle is only pushed when the queue has room for it.
	`SOCD_ASSERT_SAME(a_push_ready, push, q_ready, "bundle pushed into a full queue")

endmodule

// File: hw/rtl/socd_queue.sv
// Two-entry queue of result bundles between the front and back parts.
// Uses socd_pkg for the bundle type and depth.
`include "socd_last_input_key_cleaner_core_defines.svh"

module socd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  socd_pkg::bundle_t push_data,
	output logic              q_ready,
	output logic              q_valid,
	output socd_pkg::bundle_t q_data,
	input  logic              pop
);

	socd_pkg::bundle_t mem_q [socd_pkg::Q_DEPTH];
	logic              wr_q;
	logic              rd_q;
	logic [1:0]        cnt_q;
	logic              do_pop;

	assign q_ready = (cnt_q != 2'(socd_pkg::Q_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_data  = mem_q[rd_q];
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`SOCD_ASSERT_SAME(a_cnt_range, 1'b1, cnt_q <= 2'(socd_pkg::Q_DEPTH), "queue count overflow")

endmodule

// File: hw/rtl/socd_back.sv
// Back part of the key cleaner: takes one bundle at a time from the queue
// and sends its results out one beat each, tlast on the final one. Uses socd_pkg.
`include "socd_last_input_key_cleaner_core_defines.svh"

module socd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  socd_pkg::bundle_t q_data,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tlast
);

	socd_pkg::bundle_t cur_q;
	logic [1:0]        idx_q;
	logic              busy_q;
	logic              m_tvalid_q;
	logic [1:0]        vk_q;
	logic              pr_q;
	logic              last_q;
	logic              adv;
	logic              fin;

	assign pop      = !busy_q && q_valid;
	assign adv      = !m_tvalid_q || m_tready;
	assign fin      = ({1'b0, idx_q} + 3'd1) == cur_q.cnt;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, pr_q, vk_q};
	assign m_tlast  = last_q;

	always_ff @(posedge clk) begin
		if (pop) cur_q <= q_data;
		if (adv && busy_q) begin
			vk_q   <= cur_q.vk[idx_q];
			pr_q   <= cur_q.pr[idx_q];
			last_q <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			busy_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				idx_q  <= '0;
				busy_q <= 1'b1;
			end else if (adv && busy_q) begin
				idx_q <= idx_q + 2'd1;
				if (fin) busy_q <= 1'b0;
			end
			if (adv) m_tvalid_q <= busy_q;
		end
	end

	`SOCD_ASSERT_SAME(a_idx_in_bundle, busy_q, {1'b0, idx_q} < cur_q.cnt, "result index past bundle")
	`SOCD_ASSERT_NEXT(a_pop_loads, pop, busy_q && idx_q == '0, "popped bundle not loaded")

endmodule

// File: hw/rtl/socd_last_input_key_cleaner_core.sv
// Top level of the last-input key cleaner.
// Instantiates socd_front, socd_queue and socd_back; uses socd_pkg.
//
// Usage: the slave stream carries key events and one-millisecond ticks, one
// per beat; tuser says which (0 event, 1 tick), tdata holds key id and action.
// The master stream carries virtual key changes, one per beat, with tlast on
// the final change caused by an input beat. Inputs that change nothing give no
// output beats. Configuration writes (per-key delays, bridge start flag) are
// taken on any cycle with cfg_we high and must be done while the block is idle.
// The first result of an input passes through the queue, the bundle register
// and the output register. Throughput: an input is accepted every cycle while
// the two-entry bundle queue has room; the output side loads each bundle, then
// sends its results one per beat and takes the next once its last is registered.
// Reset clears all key state, all delays to zero, bridging off and
// release-on-jump on. When the receiver stalls, the output beat holds and the
// queue fills; once it is full, s_tready drops until a bundle is taken.
module socd_last_input_key_cleaner_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [socd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [socd_pkg::DELAY_W-1:0]   cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // key_id [2:0], key_action [4:3]
	input  logic                           s_tuser,   // mode
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,   // virtual_key [1:0], pressed [2]
	output logic                           m_tlast
);

	logic              push;
	socd_pkg::bundle_t push_data;
	logic              q_ready;
	logic              q_valid;
	socd_pkg::bundle_t q_data;
	logic              pop;

	socd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push      (push),
		.push_data (push_data),
		.q_ready   (q_ready)
	);

	socd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.q_ready   (q_ready),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.pop       (pop)
	);

	socd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
